// ===== rtl/cal_pkg.sv =====
// ----------------------------------------------------------------------------
// cal_pkg
// Types, codes and defaults shared by the compacting array list and its cells.
// ----------------------------------------------------------------------------
package cal_pkg;

    localparam int DEPTH_DEF = 8;

    localparam int KEY_W  = 32;
    localparam int NAME_W = 64;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [KEY_W-1:0]  item_key;
        logic [NAME_W-1:0]        item_name;
        logic [2:0]               position;
    } t_in;

    typedef struct packed {
        logic [1:0]               status;
        logic [2:0]               found_position;
        logic signed [KEY_W-1:0]  out_key;
        logic [NAME_W-1:0]        out_name;
        logic [3:0]               entry_total;
        logic                     is_empty;
        logic                     is_full;
    } t_out;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

// ===== rtl/cal_cell.sv =====
// ----------------------------------------------------------------------------
// cal_cell
// One list slot: holds a key and name, loads a new entry, takes its right
// neighbor's entry on a shift, and compares its name against the search tag.
// ----------------------------------------------------------------------------
module cal_cell (
    input  logic                              i_clk,
    input  cal_pkg::t_cell_ctl                i_ctl,
    input  logic signed [cal_pkg::KEY_W-1:0]  i_key,
    input  logic [cal_pkg::NAME_W-1:0]        i_name,
    input  logic signed [cal_pkg::KEY_W-1:0]  i_nb_key,
    input  logic [cal_pkg::NAME_W-1:0]        i_nb_name,
    output logic signed [cal_pkg::KEY_W-1:0]  o_key,
    output logic [cal_pkg::NAME_W-1:0]        o_name,
    output logic                              o_match
);

    logic signed [cal_pkg::KEY_W-1:0] r_key;
    logic [cal_pkg::NAME_W-1:0]       r_name;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key  <= i_key;
            r_name <= i_name;
        end else if (i_ctl.shift) begin
            r_key  <= i_nb_key;
            r_name <= i_nb_name;
        end
    end

    assign o_key   = r_key;
    assign o_name  = r_name;
    assign o_match = (r_name == i_name);

endmodule

// ===== rtl/compacting_array_list.sv =====
// ----------------------------------------------------------------------------
// compacting_array_list
// Ordered list of up to DEPTH key/name entries with append, remove-at-position
// with compaction, and search by name.
//
// Input channel: i_in_valid / o_in_stall carry one command (t_in). Output
// channel: o_out_valid / i_out_stall carry one result (t_out) per command.
// Each command is executed at its transfer: the row of cells updates in that
// cycle (append loads one cell, removal shifts every later cell down by one)
// and the result is registered in the single output register, so a new command
// can be taken every cycle while o_in_stall is low. All cells compare their
// names in parallel for a search.
// While a result waits under i_out_stall, no new command is taken. Reset
// empties the list and drops any pending result; slot contents and the result
// register are kept, only the count and the valid flag are cleared.
// ----------------------------------------------------------------------------
module compacting_array_list #(
    parameter int DEPTH = cal_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cal_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cal_pkg::t_out o_out_data
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 3) ? CW : 3;

    logic [CW-1:0]  r_count, n_count;
    logic           r_out_valid;
    cal_pkg::t_out  r_out, n_out;
    logic           acc;
    logic           full, remove_ok;

    cal_pkg::t_cell_ctl                cell_ctl  [DEPTH];
    logic signed [cal_pkg::KEY_W-1:0]  cell_key  [DEPTH];
    logic [cal_pkg::NAME_W-1:0]        cell_name [DEPTH];
    logic signed [cal_pkg::KEY_W-1:0]  nb_key    [DEPTH];
    logic [cal_pkg::NAME_W-1:0]        nb_name   [DEPTH];
    logic [DEPTH-1:0]                  cell_match;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign acc        = i_in_valid && !o_in_stall;
    assign full       = (r_count == CW'(DEPTH));
    assign remove_ok  = (r_count != '0) &&
                        (CMPW'(i_in_data.position) < CMPW'(r_count));

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == DEPTH - 1) begin : g_last
                assign nb_key[g]  = '0;
                assign nb_name[g] = '0;
            end else begin : g_mid
                assign nb_key[g]  = cell_key[g+1];
                assign nb_name[g] = cell_name[g+1];
            end

            assign cell_ctl[g].load  = acc && (i_in_data.cmd == cal_pkg::CMD_INSERT) &&
                                       !full && (CMPW'(g) == CMPW'(r_count));
            assign cell_ctl[g].shift = acc && (i_in_data.cmd == cal_pkg::CMD_REMOVE) &&
                                       remove_ok &&
                                       (CMPW'(g) >= CMPW'(i_in_data.position));

            cal_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (cell_ctl[g]),
                .i_key     (i_in_data.item_key),
                .i_name    (i_in_data.item_name),
                .i_nb_key  (nb_key[g]),
                .i_nb_name (nb_name[g]),
                .o_key     (cell_key[g]),
                .o_name    (cell_name[g]),
                .o_match   (cell_match[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        n_out   = '0;
        case (i_in_data.cmd)
            cal_pkg::CMD_INSERT: begin
                if (full) begin
                    n_out.status = cal_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            cal_pkg::CMD_REMOVE: begin
                if (!remove_ok) begin
                    n_out.status = cal_pkg::ST_RANGE;
                end else begin
                    n_count = r_count - CW'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CMPW'(i) == CMPW'(i_in_data.position)) begin
                            n_out.out_key  = cell_key[i];
                            n_out.out_name = cell_name[i];
                        end
                    end
                end
            end
            cal_pkg::CMD_SEARCH: begin
                n_out.status = cal_pkg::ST_NOTFOUND;
                // scan from the top so the lowest matching slot wins
                for (int i = DEPTH - 1; i >= 0; i--) begin
                    if (cell_match[i] && (CMPW'(i) < CMPW'(r_count))) begin
                        n_out.status         = cal_pkg::ST_OK;
                        n_out.found_position = 3'(i);
                    end
                end
            end
            default: begin
            end
        endcase
        n_out.entry_total = 4'(n_count);
        n_out.is_empty    = (n_count == '0);
        n_out.is_full     = (n_count == CW'(DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_in_data.cmd == cal_pkg::CMD_INSERT) && !full
        |=> r_count == $past(r_count) + CW'(1))
        else $error("append did not grow the list");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_in_data.cmd == cal_pkg::CMD_REMOVE) && remove_ok
        |=> r_count == $past(r_count) - CW'(1))
        else $error("removal did not shrink the list");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_count))
        else $error("count changed without a transfer");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.is_empty && o_out_data.is_full))
        else $error("result flags both empty and full");

endmodule

// ===== tb/tb_compacting_array_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compacting_array_list
// Self-checking bench for the compacting array list. A directed sequence
// covers empty, full, out-of-range, no-match, duplicate-name and spare-code
// cases. It is followed by random command streams that swing the fill level
// between empty and full, with names drawn mostly from a small pool so that
// searches hit. Both channels idle at random. The receiver holds off for long
// stretches so the block backs up. A scoreboard keeps its own copy of the
// list, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_compacting_array_list;
    import cal_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int RANDOM_CMDS = 1850;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_REPORTS = 10;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    class list_checker;
        logic signed [KEY_W-1:0] keys [DEPTH];
        logic [NAME_W-1:0]       names[DEPTH];
        int unsigned             count;
        t_out                    pending_results[$];
        int                      errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function t_out apply_command(t_in c);
            t_out r;
            int   i;
            r = '0;
            case (c.cmd)
                CMD_INSERT: begin
                    if (count >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        keys[count]  = c.item_key;
                        names[count] = c.item_name;
                        count++;
                    end
                end
                CMD_REMOVE: begin
                    if (count == 0 || c.position >= count) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.out_key  = keys[c.position];
                        r.out_name = names[c.position];
                        count--;
                        for (i = c.position; i < count; i++) begin
                            keys[i]  = keys[i+1];
                            names[i] = names[i+1];
                        end
                    end
                end
                CMD_SEARCH: begin
                    r.status = ST_NOTFOUND;
                    for (i = 0; i < count && r.status == ST_NOTFOUND; i++) begin
                        if (names[i] == c.item_name) begin
                            r.status         = ST_OK;
                            r.found_position = i[2:0];
                        end
                    end
                end
                default: ;
            endcase
            r.entry_total = count[3:0];
            r.is_empty    = (count == 0);
            r.is_full     = (count >= DEPTH);
            return r;
        endfunction

        function string show(t_out r);
            return $sformatf("st=%0d pos=%0d key=%0d name=%h total=%0d empty=%0b full=%0b",
                             r.status, r.found_position, r.out_key,
                             r.out_name, r.entry_total, r.is_empty, r.is_full);
        endfunction

        function void note_input(t_in c);
            pending_results.push_back(apply_command(c));
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: %s", show(got));
                return;
            end
            want = pending_results.pop_front();
            if (want.status !== got.status || want.found_position !== got.found_position ||
                want.out_key !== got.out_key || want.out_name !== got.out_name ||
                want.entry_total !== got.entry_total || want.is_empty !== got.is_empty ||
                want.is_full !== got.is_full) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("mismatch at %0t", $realtime);
                    $display("  expected: %s", show(want));
                    $display("  actual:   %s", show(got));
                end
            end
        endfunction
    endclass

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_in   i_in_data   = '0;
    logic  i_out_stall = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_out  o_out_data;

    list_checker       board = new();
    logic [NAME_W-1:0] name_pool[12];
    bit                hold_off_req = 0;
    bit                sender_quiet = 0;

    compacting_array_list #(.DEPTH(DEPTH)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                board.note_input(i_in_data);
            if (o_out_valid && !i_out_stall)
                board.check_result(o_out_data);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stall per result, quiet stretches, long hold-off on request
    initial begin : receiver
        int taken;
        int n;
        bit quiet;
        taken = 0;
        quiet = 0;
        forever begin
            if (taken % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            n = quiet ? 0 : $urandom_range(0, 16);
            if (hold_off_req) begin
                hold_off_req = 0;
                n = HOLD_CYCLES;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
        end
    end

    task automatic send_command(input t_in c, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    function automatic int draw_gap();
        return sender_quiet ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic t_in make_cmd(logic [1:0] cmd, logic signed [KEY_W-1:0] key,
                                     logic [NAME_W-1:0] name, logic [2:0] pos);
        t_in c;
        c.cmd       = cmd;
        c.item_key  = key;
        c.item_name = name;
        c.position  = pos;
        return c;
    endfunction

    function automatic t_in random_cmd(t_mix mix);
        int          r;
        int          lim_ins;
        int          lim_rem;
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [63:0] name;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin lim_ins = 55; lim_rem = 75; end
            MIX_DRAIN: begin lim_ins = 20; lim_rem = 70; end
            default:   begin lim_ins = 35; lim_rem = 65; end
        endcase
        if (r < lim_ins)      cmd = CMD_INSERT;
        else if (r < lim_rem) cmd = CMD_REMOVE;
        else if (r < 97)      cmd = CMD_SEARCH;
        else                  cmd = CMD_SPARE;
        case ($urandom_range(0, 9))
            0:       key = 32'h8000_0000;
            1:       key = 32'h7FFF_FFFF;
            default: key = $urandom;
        endcase
        if ($urandom_range(0, 9) == 0)
            name = {$urandom, $urandom};
        else
            name = name_pool[$urandom_range(0, 11)];
        return make_cmd(cmd, key, name, 3'($urandom_range(0, 7)));
    endfunction

    initial begin : stimulus
        t_mix mix;
        int   i;
        int   burst_left;
        name_pool[0] = '0;
        name_pool[1] = '1;
        for (i = 2; i < 12; i++)
            name_pool[i] = {$urandom, $urandom};
        burst_left = 0;
        mix        = MIX_EVEN;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list corner cases
        send_command(make_cmd(CMD_REMOVE, 0, '0, 3'd0), 0);
        send_command(make_cmd(CMD_SEARCH, 0, '0, 3'd0), 1);
        send_command(make_cmd(CMD_SPARE, -1, '1, 3'd7), 0);
        // fill with extreme keys and names, one duplicate name
        send_command(make_cmd(CMD_INSERT, 32'sh8000_0000, '0, 3'd0), 0);
        send_command(make_cmd(CMD_INSERT, 32'sh7FFF_FFFF, '1, 3'd7), 2);
        send_command(make_cmd(CMD_INSERT, 0, 64'h5555_5555_5555_5555, 3'd0), 0);
        send_command(make_cmd(CMD_INSERT, -1, 64'hAAAA_AAAA_AAAA_AAAA, 3'd0), 0);
        send_command(make_cmd(CMD_INSERT, 32'sh5555_5555, '1, 3'd0), 3);
        send_command(make_cmd(CMD_INSERT, 32'sh2AAA_AAAA, 64'h0123_4567_89AB_CDEF, 3'd0), 0);
        send_command(make_cmd(CMD_INSERT, 7, 64'hFEDC_BA98_7654_3210, 3'd0), 0);
        send_command(make_cmd(CMD_INSERT, -7, 64'h8000_0000_0000_0001, 3'd0), 0);
        send_command(make_cmd(CMD_INSERT, 1, 64'h1, 3'd0), 0);
        // search first of duplicates, last slot, and a miss
        send_command(make_cmd(CMD_SEARCH, 0, '1, 3'd0), 0);
        send_command(make_cmd(CMD_SEARCH, 0, 64'h8000_0000_0000_0001, 3'd0), 0);
        send_command(make_cmd(CMD_SEARCH, 0, 64'h1, 3'd0), 0);
        send_command(make_cmd(CMD_SPARE, 0, '0, 3'd0), 0);
        // drain: last, first, middle, then out of range
        send_command(make_cmd(CMD_REMOVE, 0, '0, 3'd7), 0);
        send_command(make_cmd(CMD_REMOVE, 0, '0, 3'd0), 1);
        send_command(make_cmd(CMD_REMOVE, 0, '0, 3'd3), 0);
        send_command(make_cmd(CMD_REMOVE, 0, '0, 3'd6), 0);
        send_command(make_cmd(CMD_REMOVE, 0, '0, 3'd5), 0);
        send_command(make_cmd(CMD_SEARCH, 0, '1, 3'd0), 0);

        for (i = 0; i < RANDOM_CMDS; i++) begin
            if (i % 40 == 0)
                mix = t_mix'($urandom_range(0, 2));
            if (i % 64 == 0)
                sender_quiet = ($urandom_range(0, 3) == 0);
            if (i % 97 == 0)
                name_pool[$urandom_range(2, 11)] = {$urandom, $urandom};
            if (i == 600 || i == 1400) begin
                hold_off_req = 1;
                burst_left   = 30;
            end
            if (burst_left > 0) begin
                burst_left--;
                send_command(random_cmd(mix), 0);
            end else begin
                send_command(random_cmd(mix), draw_gap());
            end
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
